// ===== sv/pidci_pkg.sv =====
// Package for the PID controller with clamped integrator.
// Holds the register indexes, the field widths and the stage-to-stage structs.
// No dependencies; used by every module of the block but pidci_checker.
`default_nettype none

package pidci_pkg;

  // Field widths
  localparam int GainW    = 16;
  localparam int LimitW   = 16;
  localparam int TargetW  = 16;
  localparam int MeasW    = 24;
  localparam int DriveW   = 24;
  localparam int FracW    = 8;   // Q.8 fraction bits of error, sum and drive
  localparam int GainFracW = 12; // Q4.12 gain fraction bits

  // Internal widths
  localparam int ErrW   = 25;  // target*256 - measured
  localparam int SumW   = 26;  // stored sum plus error, also the derivative
  localparam int AccW   = 24;  // clamped stored sum
  localparam int PErrW  = GainW + ErrW - GainFracW;  // 29
  localparam int PSumW  = GainW + SumW - GainFracW;  // 30
  localparam int DrvSumW = 32;

  // Configuration port
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_LIMIT_HIGH = 3'd3,
    REG_LIMIT_LOW  = 3'd4
  } reg_idx_t;

  // Register values after reset
  localparam logic signed [GainW-1:0]  GainPReset = 16'sd410;
  localparam logic signed [GainW-1:0]  GainIReset = 16'sd0;
  localparam logic signed [GainW-1:0]  GainDReset = 16'sd2048;
  localparam logic signed [LimitW-1:0] LimHiReset = 16'sd20;
  localparam logic signed [LimitW-1:0] LimLoReset = -16'sd20;

  typedef struct packed {
    logic signed [GainW-1:0]  gain_p;
    logic signed [GainW-1:0]  gain_i;
    logic signed [GainW-1:0]  gain_d;
    logic signed [LimitW-1:0] limit_high;
    logic signed [LimitW-1:0] limit_low;
  } cfg_t;

  // Operands after the error/sum stage
  typedef struct packed {
    logic                   clr;
    logic signed [ErrW-1:0] err;
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] deriv;
  } opnd_t;

  // Truncated products after the multiply stage
  typedef struct packed {
    logic                    clr;
    logic signed [PErrW-1:0] p_err;
    logic signed [PSumW-1:0] p_sum;
    logic signed [PSumW-1:0] p_der;
  } prod_t;

endpackage

`default_nettype wire

// ===== sv/pidci_cfg.sv =====
// Configuration registers of the PID controller: gains and limits.
// Depends on pidci_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module pidci_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pidci_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [pidci_pkg::GainW-1:0]      cfg_data,
  output pidci_pkg::cfg_t                       cfg
);

  // Always take a write; unknown indexes drop the word
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p     <= pidci_pkg::GainPReset;
      cfg.gain_i     <= pidci_pkg::GainIReset;
      cfg.gain_d     <= pidci_pkg::GainDReset;
      cfg.limit_high <= pidci_pkg::LimHiReset;
      cfg.limit_low  <= pidci_pkg::LimLoReset;
    end else if (cfg_valid) begin
      case (pidci_pkg::reg_idx_t'(cfg_index))
        pidci_pkg::REG_GAIN_P:     cfg.gain_p     <= cfg_data;
        pidci_pkg::REG_GAIN_I:     cfg.gain_i     <= cfg_data;
        pidci_pkg::REG_GAIN_D:     cfg.gain_d     <= cfg_data;
        pidci_pkg::REG_LIMIT_HIGH: cfg.limit_high <= cfg_data;
        pidci_pkg::REG_LIMIT_LOW:  cfg.limit_low  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/pidci_state.sv =====
// Input register, error/sum/derivative logic and the controller state.
// Depends on pidci_pkg; feeds opnd_t words to the multiply stage.
`default_nettype none

module pidci_state (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pidci_pkg::cfg_t                    cfg,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_func,
  input  wire logic signed [pidci_pkg::TargetW-1:0] in_target,
  input  wire logic signed [pidci_pkg::MeasW-1:0] in_measured,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output pidci_pkg::opnd_t                        out_opnd
);

  logic                                     v1;
  logic                                     func1;
  logic signed [pidci_pkg::TargetW-1:0]     target1;
  logic signed [pidci_pkg::MeasW-1:0]       measured1;

  logic signed [pidci_pkg::AccW-1:0]        error_sum;
  logic signed [pidci_pkg::ErrW-1:0]        last_error;

  logic                                     ld2;
  logic signed [pidci_pkg::ErrW-1:0]        err;
  logic signed [pidci_pkg::SumW-1:0]        sum;
  logic signed [pidci_pkg::SumW-1:0]        deriv;
  logic signed [pidci_pkg::SumW-1:0]        hi;
  logic signed [pidci_pkg::SumW-1:0]        lo;
  logic signed [pidci_pkg::AccW-1:0]        error_sum_next;

  // Handshake: the input register refills whenever its word moves on
  assign ld2      = !out_valid || out_ready;
  assign in_ready = !v1 || ld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func1     <= in_func;
      target1   <= in_target;
      measured1 <= in_measured;
    end
  end

  // Error in Q.8, running sum and derivative
  assign err   = $signed({target1[pidci_pkg::TargetW-1], target1, 8'h00})
               - $signed({measured1[pidci_pkg::MeasW-1], measured1});
  assign sum   = $signed({{2{error_sum[pidci_pkg::AccW-1]}}, error_sum})
               + $signed({err[pidci_pkg::ErrW-1], err});
  assign deriv = $signed({err[pidci_pkg::ErrW-1], err})
               - $signed({last_error[pidci_pkg::ErrW-1], last_error});

  // Limits scaled to Q.8
  assign hi = $signed({{2{cfg.limit_high[pidci_pkg::LimitW-1]}}, cfg.limit_high, 8'h00});
  assign lo = $signed({{2{cfg.limit_low[pidci_pkg::LimitW-1]}}, cfg.limit_low, 8'h00});

  // Clamp the stored sum: high limit first, then low
  always_comb begin
    if (sum > hi) begin
      error_sum_next = hi[pidci_pkg::AccW-1:0];
    end else if (sum < lo) begin
      error_sum_next = lo[pidci_pkg::AccW-1:0];
    end else begin
      error_sum_next = sum[pidci_pkg::AccW-1:0];
    end
  end

  // Update state as the word leaves for the multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (ld2 && v1) begin
      if (func1) begin
        error_sum  <= '0;
        last_error <= '0;
      end else begin
        error_sum  <= error_sum_next;
        last_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1) begin
      out_opnd.clr   <= func1;
      out_opnd.err   <= err;
      out_opnd.sum   <= sum;
      out_opnd.deriv <= deriv;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pidci_mult.sv =====
// Multiply stage: three gain products, each truncated (floor) to Q.8.
// Depends on pidci_pkg; takes opnd_t words and gives prod_t words.
`default_nettype none

module pidci_mult (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pidci_pkg::cfg_t   cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pidci_pkg::opnd_t  in_opnd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pidci_pkg::prod_t       out_prod
);

  localparam int PeW = pidci_pkg::GainW + pidci_pkg::ErrW;
  localparam int PsW = pidci_pkg::GainW + pidci_pkg::SumW;

  logic signed [PeW-1:0] pe;
  logic signed [PsW-1:0] ps;
  logic signed [PsW-1:0] pd;

  assign in_ready = !out_valid || out_ready;

  // Full-width signed products
  assign pe = PeW'(cfg.gain_p) * PeW'(in_opnd.err);
  assign ps = PsW'(cfg.gain_i) * PsW'(in_opnd.sum);
  assign pd = PsW'(cfg.gain_d) * PsW'(in_opnd.deriv);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Drop the 12 gain fraction bits: arithmetic shift floors
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_prod.clr   <= in_opnd.clr;
      out_prod.p_err <= pe[PeW-1:pidci_pkg::GainFracW];
      out_prod.p_sum <= ps[PsW-1:pidci_pkg::GainFracW];
      out_prod.p_der <= pd[PsW-1:pidci_pkg::GainFracW];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pidci_sat.sv =====
// Output stage: adds the three products, saturates to the limits, holds the result word.
// Depends on pidci_pkg; drives the master-side stream.
`default_nettype none

module pidci_sat (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pidci_pkg::cfg_t                   cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire pidci_pkg::prod_t                  in_prod,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [pidci_pkg::DriveW-1:0]    out_drive,
  output logic                                   out_saturated
);

  localparam int W = pidci_pkg::DrvSumW;

  logic signed [W-1:0]                 drv;
  logic signed [W-1:0]                 hi;
  logic signed [W-1:0]                 lo;
  logic signed [pidci_pkg::DriveW-1:0] drive_next;
  logic                                sat_next;

  assign in_ready = !out_valid || out_ready;

  assign drv = W'(in_prod.p_err) + W'(in_prod.p_sum) + W'(in_prod.p_der);
  assign hi  = $signed({{8{cfg.limit_high[pidci_pkg::LimitW-1]}}, cfg.limit_high, 8'h00});
  assign lo  = $signed({{8{cfg.limit_low[pidci_pkg::LimitW-1]}}, cfg.limit_low, 8'h00});

  // Saturate: high limit first, then low; clear gives zero
  always_comb begin
    if (in_prod.clr) begin
      drive_next = '0;
      sat_next   = 1'b0;
    end else if (drv > hi) begin
      drive_next = hi[pidci_pkg::DriveW-1:0];
      sat_next   = 1'b1;
    end else if (drv < lo) begin
      drive_next = lo[pidci_pkg::DriveW-1:0];
      sat_next   = 1'b1;
    end else begin
      drive_next = drv[pidci_pkg::DriveW-1:0];
      sat_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_drive     <= drive_next;
      out_saturated <= sat_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pid_with_clamped_integrator.sv =====
// PID controller with clamped integrator. Takes one word per clock cycle when the
// output is not stalled and returns one result word per input word, passing it through
// the input register, operand register (error, sum, derivative and the state update),
// product register (three 16-bit by up to 26-bit multiplies) and output register (sum
// of products and saturation). The sustained rate of one word per cycle is set by the
// state loop in the first stage, one add and one clamp compare. A clear word (tuser = 1)
// zeroes the integrator and previous error and returns drive 0, not saturated.
// Configuration writes take effect at once and are meant to be made while no word is in
// flight.
// Depends on pidci_pkg, pidci_cfg, pidci_state, pidci_mult and pidci_sat.
`default_nettype none

module pid_with_clamped_integrator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pidci_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [pidci_pkg::GainW-1:0]     cfg_data,
  // Slave side
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [39:0]                     s_tdata,  // target[15:0], measured[39:16]
  input  wire logic [0:0]                      s_tuser,  // func[0]
  // Master side
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [23:0]                          m_tdata,  // drive[23:0]
  output logic [0:0]                           m_tuser   // saturated[0]
);

  pidci_pkg::cfg_t   cfg;
  pidci_pkg::opnd_t  opnd;
  pidci_pkg::prod_t  prod;
  logic              opnd_valid;
  logic              opnd_ready;
  logic              prod_valid;
  logic              prod_ready;
  logic signed [pidci_pkg::DriveW-1:0] drive;
  logic              saturated;

  pidci_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidci_state u_state (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_func     (s_tuser[0]),
    .in_target   ($signed(s_tdata[15:0])),
    .in_measured ($signed(s_tdata[39:16])),
    .out_valid   (opnd_valid),
    .out_ready   (opnd_ready),
    .out_opnd    (opnd)
  );

  pidci_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (opnd_valid),
    .in_ready  (opnd_ready),
    .in_opnd   (opnd),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod)
  );

  pidci_sat u_sat (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (prod_valid),
    .in_ready      (prod_ready),
    .in_prod       (prod),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_drive     (drive),
    .out_saturated (saturated)
  );

  assign m_tdata    = drive;
  assign m_tuser[0] = saturated;

endmodule

`default_nettype wire

// ===== sv/pidci_checker.sv =====
// Port-level checks for the PID controller, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module pidci_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_ready,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  // With no result pending the whole pipeline moves, so input is taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready && cfg_ready)
    else $error("input stalled while output is empty");

  // A clipped drive sits on an integer limit
  a_sat_integer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'h00)
    else $error("saturated drive has a fraction");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

endmodule

bind pid_with_clamped_integrator pidci_checker u_pidci_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg_ready),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);

`default_nettype wire

// ===== tb/pidci_tb_pkg.sv =====
// Shared testbench codes for the PID controller with clamped integrator.
// Holds the function codes carried in tuser; no dependencies.
`default_nettype none

package pidci_tb_pkg;

  typedef enum logic {
    FUNC_STEP  = 1'b0,
    FUNC_CLEAR = 1'b1
  } pid_func_t;

endpackage

`default_nettype wire

// ===== tb/pid_checker.sv =====
// Passive checker for pid_with_clamped_integrator: tracks register writes,
// predicts each drive word from the accepted input words and compares results.
// Depends on pidci_pkg and pidci_tb_pkg.
`default_nettype none

module pid_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [pidci_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [pidci_pkg::GainW-1:0]   cfg_data,
  input  wire logic                          s_tvalid,
  input  wire logic                          s_tready,
  input  wire logic [39:0]                   s_tdata,  // target[15:0], measured[39:16]
  input  wire logic [0:0]                    s_tuser,  // func[0]
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [23:0]                   m_tdata,  // drive[23:0]
  input  wire logic [0:0]                    m_tuser,  // saturated[0]
  output int                                 fail_count,
  output int                                 outstanding,
  output int                                 steps_seen,
  output int                                 clears_seen,
  output int                                 clips_seen
);
  import pidci_pkg::*;
  import pidci_tb_pkg::*;

  localparam int MaxReports = 40;

  typedef struct packed {
    logic signed [23:0] drive;
    logic               saturated;
  } pid_result_t;

  // Local copy of the registers and the controller state
  cfg_t               settings;
  logic signed [23:0] integ;
  logic signed [25:0] prev_err;

  pid_result_t expected_drives[$];

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < MaxReports)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // One control step: error, running sum, derivative, three truncated products,
  // then clamp the sum and saturate the drive against the scaled limits; a clear zeroes the state
  function automatic pid_result_t pid_step_predict(input logic clear,
                                                   input logic signed [15:0] target,
                                                   input logic signed [23:0] measured);
    longint err, total, slope, drv, hi, lo;
    pid_result_t r;
    r = '0;
    if (clear) begin
      integ = '0;
      prev_err = '0;
      return r;
    end
    hi = longint'($signed(settings.limit_high)) * 256;
    lo = longint'($signed(settings.limit_low)) * 256;
    err = longint'(target) * 256 - longint'(measured);
    total = longint'(integ) + err;
    slope = err - longint'(prev_err);
    prev_err = 26'(err);
    // arithmetic shift floors toward minus infinity
    drv = ((longint'($signed(settings.gain_p)) * err) >>> 12)
        + ((longint'($signed(settings.gain_i)) * total) >>> 12)
        + ((longint'($signed(settings.gain_d)) * slope) >>> 12);
    // high limit is tested first; with inverted limits the sum lands on hi or lo
    if (total > hi) total = hi;
    else if (total < lo) total = lo;
    integ = 24'(total);
    if (drv > hi) begin
      drv = hi;
      r.saturated = 1'b1;
    end else if (drv < lo) begin
      drv = lo;
      r.saturated = 1'b1;
    end
    r.drive = 24'(drv);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pid_result_t want;
    pid_result_t got;
    if (rst) begin
      settings = '{gain_p: GainPReset, gain_i: GainIReset, gain_d: GainDReset,
                   limit_high: LimHiReset, limit_low: LimLoReset};
      integ = '0;
      prev_err = '0;
      expected_drives.delete();
      fail_count = 0;
      steps_seen = 0;
      clears_seen = 0;
      clips_seen = 0;
    end else begin
      // Apply register writes
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN_P:     settings.gain_p = cfg_data;
          REG_GAIN_I:     settings.gain_i = cfg_data;
          REG_GAIN_D:     settings.gain_d = cfg_data;
          REG_LIMIT_HIGH: settings.limit_high = cfg_data;
          REG_LIMIT_LOW:  settings.limit_low = cfg_data;
          default: ;
        endcase
      end
      // Compare each result word with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.drive = m_tdata;
        got.saturated = m_tuser[0];
        if (expected_drives.size() == 0) begin
          report_mismatch("result word with nothing pending", longint'(got.drive), 0);
        end else begin
          want = expected_drives.pop_front();
          if (got.drive != want.drive)
            report_mismatch("drive", longint'(got.drive), longint'(want.drive));
          if (got.saturated != want.saturated)
            report_mismatch("saturated", longint'(got.saturated), longint'(want.saturated));
          if (want.saturated) clips_seen++;
        end
      end
      // Predict for each accepted input word
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == FUNC_CLEAR) clears_seen++;
        else steps_seen++;
        expected_drives.push_back(pid_step_predict(s_tuser[0] == FUNC_CLEAR,
                                                   s_tdata[15:0], s_tdata[39:16]));
      end
    end
    outstanding <= expected_drives.size();
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the testbench for pid_with_clamped_integrator: clock, reset, register
// programming, input words with bursts and gaps, a stalling receiver and the verdict.
// Depends on pidci_pkg, pidci_tb_pkg, pid_checker and the block itself.
`default_nettype none

module testbench;
  import pidci_pkg::*;
  import pidci_tb_pkg::*;

  localparam int RandomPhases  = 8;
  localparam int ItemsPerPhase = 205;
  localparam int SteadyItems   = 40;
  localparam int LongHold      = 100;
  localparam int DrainCycles   = 8;
  localparam int CycleLimit    = 400000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [GainW-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata = '0;   // target[15:0], measured[39:16]
  logic [0:0]           s_tuser = '0;   // func[0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;        // drive[23:0]
  logic [0:0]           m_tuser;        // saturated[0]

  logic hold_req = 1'b0;
  bit   steady = 1'b0;
  int   burst_left = 0;
  int   settings_used = 1;

  int fail_count, outstanding, steps_seen, clears_seen, clips_seen;

  pid_with_clamped_integrator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  pid_checker watch (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .outstanding(outstanding), .steps_seen(steps_seen),
    .clears_seen(clears_seen), .clips_seen(clips_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk);
      cyc++;
    end
    $display("timeout after %0d cycles with %0d words pending", CycleLimit, outstanding);
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random ready patterns, plus one long hold-off on request
  initial begin : receiver
    int mode, left, k;
    bit held;
    mode = 0;
    left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        for (k = 1; k < LongHold; k++) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(1, 60);
        end
        left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one word, with a random gap at the start of each burst
  task automatic send_word(input pid_func_t f, input logic [15:0] t, input logic [23:0] m);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {m, t};
    s_tuser <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid and hold until every predicted word has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic put_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all five registers back to back
  task automatic program_regs(input cfg_t c);
    put_reg(REG_GAIN_P, c.gain_p);
    put_reg(REG_GAIN_I, c.gain_i);
    put_reg(REG_GAIN_D, c.gain_d);
    put_reg(REG_LIMIT_HIGH, c.limit_high);
    put_reg(REG_LIMIT_LOW, c.limit_low);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] random_gain();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      1: return 16'($urandom);
      2: return 16'(int'($urandom_range(0, 8192)) - 4096);
      default: return 16'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.gain_p = random_gain();
    c.gain_i = random_gain();
    c.gain_d = random_gain();
    case ($urandom_range(0, 5))
      0, 1: begin
        c.limit_high = 16'($urandom_range(1, 300));
        c.limit_low = 16'(-int'($urandom_range(1, 300)));
      end
      2: begin
        c.limit_high = 16'h7fff;
        c.limit_low = 16'h8000;
      end
      3, 4: begin
        c.limit_high = 16'($urandom);
        c.limit_low = 16'($urandom);
      end
      default: begin
        // inverted: low limit above high limit
        c.limit_low = 16'($urandom_range(0, 100));
        c.limit_high = 16'(int'(c.limit_low) - int'($urandom_range(1, 100)));
      end
    endcase
    return c;
  endfunction

  // Mostly tracking words with measurement near setpoint; the rest clears, noise and corners
  task automatic send_random();
    int pick;
    longint t, m;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_word(FUNC_CLEAR, 16'($urandom), 24'($urandom));
    end else if (pick < 66) begin
      if ($urandom_range(0, 1) != 0) t = longint'($urandom_range(0, 400)) - 200;
      else t = longint'($signed(16'($urandom)));
      m = t * 256 + longint'($urandom_range(0, 4000)) - 2000;
      if (m > 8388607) m = 8388607;
      if (m < -8388608) m = -8388608;
      send_word(FUNC_STEP, 16'(t), 24'(m));
    end else if (pick < 88) begin
      send_word(FUNC_STEP, 16'($urandom), 24'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: t = 32767;
        1: t = -32768;
        2: t = 0;
        default: t = -1;
      endcase
      case ($urandom_range(0, 3))
        0: m = 8388607;
        1: m = -8388608;
        2: m = 0;
        default: m = -1;
      endcase
      send_word(FUNC_STEP, 16'(t), 24'(m));
    end
  endtask

  // Corner words under reset settings, extreme gains and inverted limits
  task automatic directed_part();
    send_word(FUNC_CLEAR, 16'h7fff, 24'h800000);
    send_word(FUNC_STEP, 16'h0000, 24'h000000);
    send_word(FUNC_STEP, 16'h7fff, 24'h800000);
    send_word(FUNC_STEP, 16'h8000, 24'h7fffff);
    send_word(FUNC_STEP, 16'h7fff, 24'h800000);
    send_word(FUNC_STEP, 16'd10, 24'd2560);
    send_word(FUNC_CLEAR, 16'h8000, 24'h7fffff);
    send_word(FUNC_STEP, 16'h0000, 24'hffffff);
    send_word(FUNC_STEP, 16'h0000, 24'h000001);
    wait_idle();
    program_regs('{gain_p: 16'h7fff, gain_i: 16'h8000, gain_d: 16'h7fff,
                   limit_high: 16'h7fff, limit_low: 16'h8000});
    settings_used++;
    send_word(FUNC_STEP, 16'h7fff, 24'h800000);
    send_word(FUNC_STEP, 16'h7fff, 24'h800000);
    send_word(FUNC_STEP, 16'h8000, 24'h7fffff);
    send_word(FUNC_STEP, 16'h0000, 24'h000001);
    send_word(FUNC_CLEAR, 16'h0000, 24'h000000);
    send_word(FUNC_STEP, 16'h0000, 24'hffffff);
    wait_idle();
    program_regs('{gain_p: 16'd4096, gain_i: 16'd4096, gain_d: 16'h8000,
                   limit_high: 16'hfffb, limit_low: 16'd5});
    settings_used++;
    send_word(FUNC_STEP, 16'h0000, 24'h000000);
    send_word(FUNC_STEP, 16'd100, 24'h000000);
    send_word(FUNC_STEP, 16'hff9c, 24'h000000);
    send_word(FUNC_STEP, 16'h0000, 24'h000000);
    send_word(FUNC_CLEAR, 16'h0000, 24'h000000);
  endtask

  initial begin : stimulus
    int ph, n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    directed_part();
    for (ph = 0; ph < RandomPhases; ph++) begin
      wait_idle();
      program_regs(random_settings());
      settings_used++;
      // once: stall the output for a long stretch while words keep coming
      if (ph == 1) begin
        hold_req <= 1'b1;
        steady = 1'b1;
        for (n = 0; n < SteadyItems; n++) send_random();
        steady = 1'b0;
      end
      for (n = 0; n < ItemsPerPhase; n++) send_random();
    end
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    $display("Run covered %0d control steps and %0d clears over %0d register settings,",
             steps_seen, clears_seen, settings_used);
    $display("including extreme gains and inverted limits; %0d drive words were clipped.",
             clips_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/pidci_pkg.sv
sv/pidci_cfg.sv
sv/pidci_state.sv
sv/pidci_mult.sv
sv/pidci_sat.sv
sv/pid_with_clamped_integrator.sv
sv/pidci_checker.sv
tb/pidci_tb_pkg.sv
tb/pid_checker.sv
tb/testbench.sv
